// ===== rtl/core/spp_pkg.sv =====
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants for the S-expression pretty printer.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int SPP_MAX_DEPTH  = 255;
    localparam int SPP_COLUMN_MAX = 1023;
    localparam int SPP_QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [1:0] REG_QUOTE_CHAR = 2'd0;
    localparam logic [1:0] REG_WRAP_COL   = 2'd1;
    localparam logic [1:0] REG_POINT_COL  = 2'd2;

    localparam logic [7:0] QUOTE_CHAR_RST = 8'd34;
    localparam logic [9:0] WRAP_COL_RST   = 10'd72;
    localparam logic [9:0] POINT_COL_RST  = 10'd99;

    // lead codes
    localparam logic [1:0] LEAD_NONE  = 2'd0;
    localparam logic [1:0] LEAD_SPACE = 2'd1;
    localparam logic [1:0] LEAD_BREAK = 2'd2;

    // characters
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LP  = 8'h28;
    localparam logic [7:0] CH_RP  = 8'h29;
    localparam logic [7:0] CH_BS  = 8'h5C;
    localparam logic [7:0] CH_X   = 8'h78;
    localparam logic [7:0] CH_Y   = 8'h79;

    // one request from the front to the back
    typedef struct packed {
        logic       is_end;   // flush request carrying the held bytes
        logic [1:0] cnt;      // held byte count (flush only)
        logic [7:0] b0;       // byte to format (normal) or first held byte
        logic [7:0] b1;
        logic [7:0] b2;
        logic       xy;       // "(xy " lookahead hit (normal only)
    } spp_op_t;

    // packed so that it drops straight onto tdata[18:0]
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [7:0] tab_count;
        logic [1:0] lead_kind;
    } spp_res_t;

endpackage

// ===== rtl/core/spp_front.sv =====
// ----------------------------------------------------------------------------
// spp_front
// Input side: three-byte delay line, xy lookahead and request issue.
// ----------------------------------------------------------------------------
module spp_front
    import spp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       op_push,
    output spp_op_t    op,
    input  logic       q_full
);

    logic [7:0] la_reg [3];
    logic [1:0] cnt_reg;
    logic       take;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        op      = '0;
        op_push = 1'b0;
        if (in_end)
        begin
            op.is_end = 1'b1;
            op.cnt    = cnt_reg;
            op.b0     = la_reg[0];
            op.b1     = la_reg[1];
            op.b2     = la_reg[2];
            op_push   = take;
        end
        else
        begin
            op.b0   = la_reg[0];
            op.xy   = (la_reg[1] == CH_X) && (la_reg[2] == CH_Y) && (in_byte == CH_SP);
            op_push = take && (cnt_reg == 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (take)
        begin
            if (in_end)
                cnt_reg <= 2'd0;
            else if (cnt_reg != 2'd3)
                cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !in_end)
        begin
            if (cnt_reg == 2'd3)
            begin
                la_reg[0] <= la_reg[1];
                la_reg[1] <= la_reg[2];
                la_reg[2] <= in_byte;
            end
            else
            begin
                la_reg[cnt_reg] <= in_byte;
            end
        end
    end

endmodule

// ===== rtl/core/spp_queue.sv =====
// ----------------------------------------------------------------------------
// spp_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module spp_queue
    import spp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  spp_op_t push_op,
    output logic    full,
    input  logic    pop,
    output logic    valid,
    output spp_op_t head
);

    localparam int PTR_W = $clog2(SPP_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(SPP_QUEUE_DEPTH + 1);

    spp_op_t          mem [SPP_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(SPP_QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = mem[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == PTR_W'(SPP_QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == PTR_W'(SPP_QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!do_push && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_op;
    end

endmodule

// ===== rtl/core/spp_back.sv =====
// ----------------------------------------------------------------------------
// spp_back
// Formatting engine: layout state, flush sequencer and output register.
// ----------------------------------------------------------------------------
module spp_back
    import spp_pkg::*;
#(
    parameter int COLUMN_MAX = SPP_COLUMN_MAX
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  quote_char,
    input  logic [9:0]  wrap_column,
    input  logic [9:0]  point_col,
    input  logic        q_valid,
    input  spp_op_t     q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output spp_res_t    m_res,
    output logic        m_last
);

    localparam int COL_W = $clog2(COLUMN_MAX + 1);
    localparam int W     = ((COL_W > 10) ? COL_W : 10) + 2;

    localparam logic PH_BYTES = 1'b0;
    localparam logic PH_LAST  = 1'b1;

    // layout state
    logic [7:0]       depth_reg, n_depth;
    logic [COL_W-1:0] col_reg, n_col;
    logic [7:0]       lnb_reg, n_lnb;
    logic             iq_reg, n_iq;
    logic             sp_reg, n_sp;
    logic             mll_reg, n_mll;
    logic             ipl_reg, n_ipl;
    logic             bs_reg, n_bs;

    // flush sequencer
    logic             phase_reg;
    logic [1:0]       idx_reg;
    logic             pend_valid_reg;
    spp_res_t         pend_reg;

    // output register
    logic             m_valid_reg;
    spp_res_t         m_res_reg;
    logic             m_last_reg;

    logic [7:0]       c;
    logic             xy;
    logic             blank;
    logic             p_emit;
    spp_res_t         p_res;
    logic [COL_W-1:0] col1;
    logic [7:0]       dep_dn;
    spp_res_t         t_res;
    logic             t_cond;
    logic             out_room;
    logic             step;
    logic             upd_state;
    logic             clr_state;
    logic             out_load;
    spp_res_t         out_val;
    logic             out_fin;
    logic             pend_load;
    spp_res_t         pend_val;

    function automatic logic [COL_W-1:0] sat_col(input logic [W-1:0] v);
        if (v > W'(COLUMN_MAX))
            return COL_W'(COLUMN_MAX);
        return v[COL_W-1:0];
    endfunction

    // byte under work
    always_comb
    begin
        c  = q_head.b0;
        xy = q_head.xy;
        if (q_head.is_end)
        begin
            xy = 1'b0;
            case (idx_reg)
                2'd1:    c = q_head.b1;
                2'd2:    c = q_head.b2;
                default: c = q_head.b0;
            endcase
        end
    end

    // per-byte formatting decision
    always_comb
    begin
        blank   = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
        n_depth = depth_reg;
        n_col   = col_reg;
        n_lnb   = lnb_reg;
        n_iq    = iq_reg;
        n_sp    = sp_reg;
        n_mll   = mll_reg;
        n_ipl   = ipl_reg;
        n_bs    = bs_reg;
        p_emit  = 1'b0;
        p_res   = '0;
        col1    = col_reg;
        dep_dn  = (depth_reg != 8'd0) ? depth_reg - 8'd1 : 8'd0;
        if (blank && !iq_reg)
        begin
            n_sp = 1'b1;
        end
        else
        begin
            p_emit         = 1'b1;
            p_res.has_byte = 1'b1;
            p_res.out_byte = c;
            n_sp           = 1'b0;
            // settle a held whitespace run
            if (sp_reg && depth_reg != 8'd0 && lnb_reg != CH_LP && c != CH_RP && c != CH_LP)
            begin
                if (ipl_reg || W'(col_reg) < W'(wrap_column))
                begin
                    p_res.lead_kind = LEAD_SPACE;
                    col1            = sat_col(W'(col_reg) + W'(1));
                end
                else
                begin
                    p_res.lead_kind = LEAD_BREAK;
                    p_res.tab_count = depth_reg;
                    col1            = sat_col(W'(depth_reg));
                    n_mll           = 1'b1;
                end
            end
            n_col = sat_col(W'(col1) + W'(1));
            if (c == CH_LP && !iq_reg)
            begin
                if (depth_reg == 8'd0)
                begin
                    n_col = sat_col(W'(col1) + W'(1));
                end
                else if (ipl_reg && xy && W'(col1) < W'(point_col))
                begin
                    p_res.lead_kind = LEAD_SPACE;
                    n_col           = sat_col(W'(col1) + W'(2));
                end
                else
                begin
                    p_res.lead_kind = LEAD_BREAK;
                    p_res.tab_count = depth_reg;
                    n_col           = sat_col(W'(depth_reg) + W'(1));
                end
                n_ipl = xy;
                if (depth_reg < 8'(SPP_MAX_DEPTH))
                    n_depth = depth_reg + 8'd1;
            end
            else if (c == CH_RP && !iq_reg)
            begin
                n_depth = dep_dn;
                if (lnb_reg == CH_RP || mll_reg)
                begin
                    p_res.lead_kind = LEAD_BREAK;
                    p_res.tab_count = dep_dn;
                    n_col           = sat_col(W'(dep_dn) + W'(1));
                    n_mll           = 1'b0;
                end
            end
            else
            begin
                if (c == CH_BS)
                begin
                    n_bs = !bs_reg;
                end
                else
                begin
                    if (c == quote_char && !bs_reg)
                        n_iq = !iq_reg;
                    n_bs = 1'b0;
                end
            end
            n_lnb = c;
        end
    end

    // trailing space or break at end of text
    always_comb
    begin
        t_cond = sp_reg && depth_reg != 8'd0 && lnb_reg != CH_LP;
        t_res  = '0;
        if (ipl_reg || W'(col_reg) < W'(wrap_column))
        begin
            t_res.lead_kind = LEAD_SPACE;
        end
        else
        begin
            t_res.lead_kind = LEAD_BREAK;
            t_res.tab_count = depth_reg;
        end
    end

    // sequencing
    always_comb
    begin
        out_room  = !m_valid_reg || m_ready;
        step      = q_valid && out_room;
        upd_state = 1'b0;
        clr_state = 1'b0;
        out_load  = 1'b0;
        out_val   = p_res;
        out_fin   = 1'b0;
        pend_load = 1'b0;
        pend_val  = p_res;
        q_pop     = 1'b0;
        if (step)
        begin
            if (!q_head.is_end)
            begin
                upd_state = 1'b1;
                out_load  = p_emit;
                q_pop     = 1'b1;
            end
            else if (phase_reg == PH_LAST)
            begin
                out_load  = pend_valid_reg;
                out_val   = pend_reg;
                out_fin   = 1'b1;
                clr_state = 1'b1;
                q_pop     = 1'b1;
            end
            else if (idx_reg < q_head.cnt)
            begin
                // hold each flushed result until the next one so the last one can be marked
                upd_state = 1'b1;
                out_load  = p_emit && pend_valid_reg;
                out_val   = pend_reg;
                pend_load = p_emit;
            end
            else
            begin
                out_load  = t_cond && pend_valid_reg;
                out_val   = pend_reg;
                pend_load = t_cond;
                pend_val  = t_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= '0;
            col_reg        <= '0;
            lnb_reg        <= '0;
            iq_reg         <= 1'b0;
            sp_reg         <= 1'b0;
            mll_reg        <= 1'b0;
            ipl_reg        <= 1'b0;
            bs_reg         <= 1'b0;
            phase_reg      <= PH_BYTES;
            idx_reg        <= 2'd0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (clr_state)
            begin
                depth_reg <= '0;
                col_reg   <= '0;
                lnb_reg   <= '0;
                iq_reg    <= 1'b0;
                sp_reg    <= 1'b0;
                mll_reg   <= 1'b0;
                ipl_reg   <= 1'b0;
                bs_reg    <= 1'b0;
            end
            else if (upd_state)
            begin
                depth_reg <= n_depth;
                col_reg   <= n_col;
                lnb_reg   <= n_lnb;
                iq_reg    <= n_iq;
                sp_reg    <= n_sp;
                mll_reg   <= n_mll;
                ipl_reg   <= n_ipl;
                bs_reg    <= n_bs;
            end

            if (step && q_head.is_end)
            begin
                unique case (phase_reg)
                    PH_BYTES:
                    begin
                        if (idx_reg < q_head.cnt)
                            idx_reg <= idx_reg + 2'd1;
                        else
                            phase_reg <= PH_LAST;
                    end
                    PH_LAST:
                    begin
                        phase_reg <= PH_BYTES;
                        idx_reg   <= 2'd0;
                    end
                    default:
                    begin
                        phase_reg <= PH_BYTES;
                    end
                endcase
            end

            if (clr_state)
                pend_valid_reg <= 1'b0;
            else if (pend_load)
                pend_valid_reg <= 1'b1;

            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_load)
            pend_reg <= pend_val;
        if (out_load)
        begin
            m_res_reg  <= out_val;
            m_last_reg <= out_fin;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;
    assign m_last  = m_last_reg;

    // a held result only exists while a flush request is at the queue head
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (q_valid && q_head.is_end))
        else $error("held result outside a flush");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LAST) |-> (q_valid && q_head.is_end && idx_reg == q_head.cnt))
        else $error("flush sequencer out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && q_head.is_end && phase_reg == PH_LAST) |=>
            (depth_reg == 8'd0 && col_reg == '0 && !pend_valid_reg && !iq_reg))
        else $error("stream state not cleared after flush");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_res_reg.lead_kind != LEAD_BREAK) |-> (m_res_reg.tab_count == 8'd0))
        else $error("tabs without a line break");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_res_reg.has_byte) |-> (m_last_reg && m_res_reg.out_byte == 8'd0))
        else $error("trailing break not marked last");

endmodule

// ===== rtl/core/sexpr_pretty_printer.sv =====
// ----------------------------------------------------------------------------
// sexpr_pretty_printer
// Reformats S-expression text arriving one byte per request.
// ----------------------------------------------------------------------------
// Input stream: s_tdata[7:0] carries a source byte; s_tlast marks the end of
// the text (its data byte is ignored) and flushes the held bytes, up to three.
// Output stream: each request is one output byte with its lead (none, space
// or newline plus tab_count tabs); has_byte low marks a trailing space or
// break and m_tlast marks the last result of a text.
// Throughput: one source byte per cycle while the queue has room. The first
// three bytes of a text are only held in the delay line; after that each
// byte releases at most one result, loaded into the output register when its
// request is taken at the back end (m_tvalid rises once an accepted byte has
// passed the queue and the output register). The flush sequencer steps an end
// request through its held bytes, one per cycle while the output has room.
// A receiver stall holds the output register; the two-entry queue absorbs
// further input, then s_tready drops until the back end moves again.
// Reset clears all stream state and loads the register defaults; registers
// are written over the APB port and keep their values across texts.
// ----------------------------------------------------------------------------
module sexpr_pretty_printer
    import spp_pkg::*;
#(
    parameter int COLUMN_MAX = SPP_COLUMN_MAX
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] lead_kind, [9:2] tab_count, [10] has_byte,
                                   // [18:11] out_byte, [23:19] zero
    output logic        m_tlast,   // final_result
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] quote_char_reg;
    logic [9:0] wrap_col_reg;
    logic [9:0] point_col_reg;
    logic       wr_en;

    spp_op_t    push_op;
    logic       push;
    logic       q_full;
    logic       q_valid;
    spp_op_t    q_head;
    logic       q_pop;
    spp_res_t   res;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_char_reg <= QUOTE_CHAR_RST;
            wrap_col_reg   <= WRAP_COL_RST;
            point_col_reg  <= POINT_COL_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_QUOTE_CHAR: quote_char_reg <= pwdata[7:0];
                REG_WRAP_COL:   wrap_col_reg   <= pwdata[9:0];
                REG_POINT_COL:  point_col_reg  <= pwdata[9:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_QUOTE_CHAR: prdata = {24'd0, quote_char_reg};
            REG_WRAP_COL:   prdata = {22'd0, wrap_col_reg};
            REG_POINT_COL:  prdata = {22'd0, point_col_reg};
            default:        prdata = 32'd0;
        endcase
    end

    spp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .op_push  (push),
        .op       (push_op),
        .q_full   (q_full)
    );

    spp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head    (q_head)
    );

    spp_back #(
        .COLUMN_MAX (COLUMN_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .quote_char  (quote_char_reg),
        .wrap_column (wrap_col_reg),
        .point_col   (point_col_reg),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_res       (res),
        .m_last      (m_tlast)
    );

    assign m_tdata = {5'd0, res};

endmodule
